/* hw/rtl/csvp_pkg.sv */
// Package for the CSV record/field parser: character codes, token and
// quote-state types, and the decode bundle passed from decoder to token buffer.
// No dependencies.
package csvp_pkg;

    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    // Most tokens one input byte can produce
    localparam int MAX_TOKENS = 3;

    typedef enum logic [1:0] {
        TOK_DATA   = 2'd0,
        TOK_FIELD  = 2'd1,
        TOK_RECORD = 2'd2
    } tok_type_t;

    typedef enum logic [1:0] {
        QM_OUTSIDE = 2'd0,
        QM_INSIDE  = 2'd1,
        QM_PENDING = 2'd2
    } quote_mode_t;

    typedef struct packed {
        tok_type_t  kind;
        logic [7:0] value;
    } token_t;

    typedef struct packed {
        quote_mode_t qmode;
        logic        cr_held;
    } parse_state_t;

    typedef struct packed {
        token_t [MAX_TOKENS-1:0] tok;
        logic [1:0]              count;
    } token_group_t;

endpackage

/* hw/rtl/csvp_decode.sv */
// Combinational byte decoder: one text byte plus the parser state in,
// up to three tokens and the next parser state out. Uses csvp_pkg.
module csvp_decode (
    input  logic [7:0]            text_byte,
    input  logic                  stream_end,
    input  csvp_pkg::parse_state_t state_cur,
    output csvp_pkg::token_group_t tokens,
    output csvp_pkg::parse_state_t state_next
);
    import csvp_pkg::*;

    always_comb begin
        token_group_t grp;
        quote_mode_t  mode;
        logic         cr_next;
        logic         closed;
        logic         consumed;

        grp      = '0;
        cr_next  = 1'b0;
        closed   = 1'b0;
        consumed = 1'b0;

        case (state_cur.qmode)
            QM_OUTSIDE: mode = QM_OUTSIDE;
            QM_PENDING: mode = QM_PENDING;
            default:    mode = QM_INSIDE; // unused code behaves as inside
        endcase

        // held CR: dropped before LF, otherwise emitted as data
        if (state_cur.cr_held && text_byte != CH_LF) begin
            grp.tok[grp.count] = '{kind: TOK_DATA, value: CH_CR};
            grp.count          = grp.count + 2'd1;
        end

        // pending quote: doubled quote or close
        if (mode == QM_PENDING) begin
            if (text_byte == CH_QUOTE) begin
                grp.tok[grp.count] = '{kind: TOK_DATA, value: CH_QUOTE};
                grp.count          = grp.count + 2'd1;
                mode               = QM_INSIDE;
                consumed           = 1'b1;
            end else begin
                mode = QM_OUTSIDE;
            end
        end

        if (!consumed) begin
            if (text_byte == CH_CR) begin
                cr_next = !stream_end;
            end else if (text_byte == CH_LF) begin
                if (mode == QM_OUTSIDE || stream_end) begin
                    grp.tok[grp.count] = '{kind: TOK_RECORD, value: 8'h00};
                    closed             = 1'b1;
                end else begin
                    grp.tok[grp.count] = '{kind: TOK_DATA, value: CH_LF};
                end
                grp.count = grp.count + 2'd1;
            end else if (text_byte == CH_QUOTE) begin
                mode = (mode == QM_OUTSIDE) ? QM_INSIDE : QM_PENDING;
            end else if (mode == QM_OUTSIDE && text_byte == CH_COMMA) begin
                grp.tok[grp.count] = '{kind: TOK_FIELD, value: 8'h00};
                grp.count          = grp.count + 2'd1;
            end else begin
                grp.tok[grp.count] = '{kind: TOK_DATA, value: text_byte};
                grp.count          = grp.count + 2'd1;
            end
        end

        // final byte closes any open record and restarts the stream state
        if (stream_end) begin
            if (!closed) begin
                grp.tok[grp.count] = '{kind: TOK_RECORD, value: 8'h00};
                grp.count          = grp.count + 2'd1;
            end
            mode    = QM_OUTSIDE;
            cr_next = 1'b0;
        end

        tokens               = grp;
        state_next.qmode     = mode;
        state_next.cr_held   = cr_next;
    end

endmodule

/* hw/rtl/csvp_token_buf.sv */
// Token buffer and output register: holds the tokens of one byte and
// drains them one beat per cycle while out_ready allows. Uses csvp_pkg.
module csvp_token_buf (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   load,
    input  csvp_pkg::token_group_t tokens,
    output logic                   load_ready,
    output logic                   out_valid,
    input  logic                   out_ready,
    output csvp_pkg::token_t       out_tok,
    output logic                   out_last
);
    import csvp_pkg::*;

    logic [1:0]                rem_reg, rem_next;
    logic [1:0]                pos_reg, pos_next;
    token_t [MAX_TOKENS-1:0]   slot_reg;
    logic                      out_valid_reg, out_valid_next;
    token_t                    out_tok_reg;
    logic                      out_last_reg;
    logic                      out_free;
    logic                      move;

    assign out_free   = !out_valid_reg || out_ready;
    assign move       = (rem_reg != 2'd0) && out_free;
    assign load_ready = (rem_reg == 2'd0) || ((rem_reg == 2'd1) && out_free);

    always_comb begin
        rem_next       = rem_reg;
        pos_next       = pos_reg;
        out_valid_next = out_valid_reg;
        if (move) begin
            rem_next       = rem_reg - 2'd1;
            pos_next       = pos_reg + 2'd1;
            out_valid_next = 1'b1;
        end else if (out_free) begin
            out_valid_next = 1'b0;
        end
        if (load) begin
            rem_next = tokens.count;
            pos_next = 2'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg       <= 2'd0;
            pos_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end else begin
            rem_reg       <= rem_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            slot_reg <= tokens.tok;
        end
        if (move) begin
            out_tok_reg  <= slot_reg[pos_reg];
            out_last_reg <= (rem_reg == 2'd1);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_tok   = out_tok_reg;
    assign out_last  = out_last_reg;

endmodule

/* hw/rtl/csv_record_field_parser_top.sv */
// Top level of the CSV record/field parser.
// Instantiates csvp_decode and csvp_token_buf; uses csvp_pkg.
//
// Streaming CSV tokenizer. Text arrives one byte per input beat, with
// s_stream_end set on the final byte of a stream. Each byte produces zero to
// three result beats: field data bytes (token type 0), field ends (1) and
// field-plus-record ends (2); m_run_end marks the last result of a byte. A
// quote opens a quoted section anywhere; inside it a doubled quote gives one
// quote byte and a single quote closes it. Commas and line feeds split fields
// and records only outside quotes, save that a final LF always ends the
// record. A CR just before an LF, or as the final byte, is dropped.
// Throughput: one byte per cycle while m_ready is high, for bytes that make
// at most one result; a byte making more holds the input until the three-slot
// token buffer, draining one beat per cycle, holds its last token. The input
// is taken while a finished result still waits in the output register.
module csv_record_field_parser_top (
    input  logic       aclk,
    input  logic       aresetn,
    // input byte channel
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_text_byte,
    input  logic       s_stream_end,
    // result channel
    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_token_type,
    output logic [7:0] m_value,
    output logic       m_run_end
);
    import csvp_pkg::*;

    parse_state_t state_reg;   // quote mode and held CR
    parse_state_t state_next;
    token_group_t tokens;
    token_t       out_tok;
    logic         accept;
    logic         buf_ready;

    assign s_ready = buf_ready;
    assign accept  = s_valid && buf_ready;

    // byte decode against current parser state
    csvp_decode u_decode (
        .text_byte  (s_text_byte),
        .stream_end (s_stream_end),
        .state_cur  (state_reg),
        .tokens     (tokens),
        .state_next (state_next)
    );

    // parser state advances only on an accepted beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '{qmode: QM_OUTSIDE, cr_held: 1'b0};
        end else if (accept) begin
            state_reg <= state_next;
        end
    end

    // token slots plus output register
    csvp_token_buf u_token_buf (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (accept),
        .tokens     (tokens),
        .load_ready (buf_ready),
        .out_valid  (m_valid),
        .out_ready  (m_ready),
        .out_tok    (out_tok),
        .out_last   (m_run_end)
    );

    assign m_token_type = out_tok.kind;
    assign m_value      = out_tok.value;

endmodule
